/* rtl/mau_pkg.sv */
// ---------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared constants and types for the modular arithmetic unit.
// ---------------------------------------------------------------------------
package mau_pkg;

  // Default residue width and modulus after reset.
  localparam int MOD_BITS_DEF = 31;
  localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

  // Request kinds.
  localparam logic [2:0] REQ_REDUCE = 3'd0;
  localparam logic [2:0] REQ_ADD    = 3'd1;
  localparam logic [2:0] REQ_SUB    = 3'd2;
  localparam logic [2:0] REQ_NEG    = 3'd3;
  localparam logic [2:0] REQ_MUL    = 3'd4;
  localparam logic [2:0] REQ_DIV    = 3'd5;
  localparam logic [2:0] REQ_INV    = 3'd6;
  localparam logic [2:0] REQ_POW    = 3'd7;

  // Control of the shared divider.
  typedef struct packed {
    logic start;
    logic short_mode;
  } div_ctl_t;

endpackage

/* rtl/modular_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// Modular arithmetic unit
// Reduce, add, subtract, negate, multiply, divide, inverse and power modulo
// a configured modulus.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays
// high until the result is shown on result for exactly one cycle with done
// high, and the receiver must take it in that cycle. Every reduction runs
// through one shift-subtract divider at one bit per cycle. Each request
// first reduces both operands, unless the modulus is below 2, which gives
// 0. A multiply forms the product and reduces it, an inverse runs extended
// Euclid steps on the divider, a divide multiplies by the inverse of its
// second operand, and power squares for every exponent bit and multiplies
// for each set one, plus an inverse for a negative exponent.
// The modulus is written through cfg_valid/cfg_ready only while the unit is
// idle.
module modular_arithmetic_unit #(
  parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [30:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        done,
  output logic [30:0] result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data
);

  logic [30:0]          modulus;
  logic [MOD_BITS-1:0]  res;
  mau_pkg::div_ctl_t    div_ctl;
  logic [63:0]          div_dividend;
  logic [MOD_BITS-1:0]  div_divisor;
  logic                 div_done;
  logic [MOD_BITS-1:0]  div_quot;
  logic [MOD_BITS-1:0]  div_rem;

  // Modulus register, written in a single beat while busy is low.
  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mau_pkg::MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  mau_seq #(.MOD_BITS(MOD_BITS)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .m            (modulus[MOD_BITS-1:0]),
    .start        (start),
    .req_type     (req_type),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .busy         (busy),
    .done         (done),
    .res          (res),
    .div_ctl      (div_ctl),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .div_rem      (div_rem)
  );

  mau_div #(.MOD_BITS(MOD_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign result = 31'(res);

endmodule

/* rtl/mau_div.sv */
// ---------------------------------------------------------------------------
// Shared shift-subtract divider
// Restoring division of a 64-bit dividend by a residue-width divisor, one
// quotient bit per cycle. Short mode divides only the low MOD_BITS bits.
// ---------------------------------------------------------------------------
module mau_div #(
  parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mau_pkg::div_ctl_t   ctl,
  input  logic [63:0]         dividend,
  input  logic [MOD_BITS-1:0] divisor,
  output logic                done,
  output logic [MOD_BITS-1:0] quot,
  output logic [MOD_BITS-1:0] rem
);

  logic [63:0]         q;
  logic [MOD_BITS:0]   r;
  logic [6:0]          cnt;
  logic                running;
  logic [MOD_BITS:0]   trial;
  logic                ge;

  // One restoring step.
  always_comb begin
    trial = {r[MOD_BITS-1:0], q[63]};
    ge    = (trial >= {1'b0, divisor});
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
        cnt     <= ctl.short_mode ? 7'(MOD_BITS) : 7'd64;
      end else if (running) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      r <= '0;
      q <= ctl.short_mode ? {dividend[MOD_BITS-1:0], {(64-MOD_BITS){1'b0}}} : dividend;
    end else if (running) begin
      r <= ge ? (trial - {1'b0, divisor}) : trial;
      q <= {q[62:0], ge};
    end
  end

  assign quot = q[MOD_BITS-1:0];
  assign rem  = r[MOD_BITS-1:0];

endmodule

/* rtl/mau_seq.sv */
// ---------------------------------------------------------------------------
// Modular arithmetic sequencer
// Steps each request through operand reduction and then, as its kind needs,
// modular multiply, extended Euclid or square-and-multiply using the shared divider.
// ---------------------------------------------------------------------------
module mau_seq #(
  parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [MOD_BITS-1:0] m,
  input  logic                start,
  input  logic [2:0]          req_type,
  input  logic [30:0]         operand_a,
  input  logic [63:0]         operand_b,
  output logic                busy,
  output logic                done,
  output logic [MOD_BITS-1:0] res,
  output mau_pkg::div_ctl_t   div_ctl,
  output logic [63:0]         div_dividend,
  output logic [MOD_BITS-1:0] div_divisor,
  input  logic                div_done,
  input  logic [MOD_BITS-1:0] div_quot,
  input  logic [MOD_BITS-1:0] div_rem
);

  localparam int W  = MOD_BITS;
  localparam int CW = MOD_BITS + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RA      = 4'd1;
  localparam logic [3:0] S_RB      = 4'd2;
  localparam logic [3:0] S_DISP    = 4'd3;
  localparam logic [3:0] S_MUL     = 4'd4;
  localparam logic [3:0] S_MULL    = 4'd5;
  localparam logic [3:0] S_MULR    = 4'd6;
  localparam logic [3:0] S_EU_CHK  = 4'd7;
  localparam logic [3:0] S_EU_DIV  = 4'd8;
  localparam logic [3:0] S_EU_FIN  = 4'd9;
  localparam logic [3:0] S_POW_CHK = 4'd10;
  localparam logic [3:0] S_POW_SQ  = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  localparam logic [1:0] DST_RES = 2'd0;
  localparam logic [1:0] DST_ACC = 2'd1;
  localparam logic [1:0] DST_SQ  = 2'd2;

  logic [3:0]          state;
  logic [2:0]          kind;
  logic [63:0]         b_raw;
  logic [W-1:0]        ar, br, x, y, acc, sq, ea, eb;
  logic [2*W-1:0]      prod;
  logic [1:0]          mdest;
  logic signed [CW-1:0] eu, ev;
  logic [63:0]         e;
  logic                eneg;

  logic [63:0]         b_mag;
  logic [W:0]          sum_ab, sub_ab;
  logic signed [CW-1:0] tv;
  logic signed [CW-1:0] nu;
  logic [CW-1:0]       u_fix;

  // Euclid steps divide by the running remainder, everything else by m.
  assign div_divisor = div_ctl.short_mode ? eb : m;

  // Shared combinational helpers. The Euclid coefficients stay within
  // plus or minus m, so the low CW bits of the product are enough.
  always_comb begin
    b_mag   = b_raw[63] ? (64'd0 - b_raw) : b_raw;
    sum_ab  = {1'b0, ar} + {1'b0, br};
    sub_ab  = (ar >= br) ? ({1'b0, ar} - {1'b0, br})
                         : ({1'b0, ar} + {1'b0, m} - {1'b0, br});
    tv      = $signed({{(CW-W){1'b0}}, div_quot}) * ev;
    nu      = eu - tv;
    if (eu[CW-1]) begin
      u_fix = CW'(eu) + {{(CW-W){1'b0}}, m};
    end else if (CW'(eu) >= {{(CW-W){1'b0}}, m}) begin
      u_fix = CW'(eu) - {{(CW-W){1'b0}}, m};
    end else begin
      u_fix = CW'(eu);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      busy            <= 1'b0;
      done            <= 1'b0;
      div_ctl.start   <= 1'b0;
      div_ctl.short_mode <= 1'b0;
    end else begin
      done          <= 1'b0;
      div_ctl.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            busy  <= 1'b1;
            kind  <= req_type;
            b_raw <= operand_b;
            if (m < W'(2)) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              div_dividend       <= {33'd0, operand_a};
              div_ctl.start      <= 1'b1;
              div_ctl.short_mode <= 1'b0;
              state              <= S_RA;
            end
          end
        end
        S_RA: begin
          if (div_done) begin
            ar                 <= div_rem;
            eneg               <= b_raw[63];
            e                  <= b_mag;
            div_dividend       <= b_mag;
            div_ctl.start      <= 1'b1;
            div_ctl.short_mode <= 1'b0;
            state              <= S_RB;
          end
        end
        S_RB: begin
          if (div_done) begin
            if (eneg && (div_rem != '0)) begin
              br <= m - div_rem;
            end else if (eneg) begin
              br <= '0;
            end else begin
              br <= div_rem;
            end
            state <= S_DISP;
          end
        end
        S_DISP: begin
          case (kind)
            mau_pkg::REQ_REDUCE: begin
              res   <= br;
              state <= S_DONE;
            end
            mau_pkg::REQ_ADD: begin
              res   <= (sum_ab >= {1'b0, m}) ? W'(sum_ab - {1'b0, m}) : sum_ab[W-1:0];
              state <= S_DONE;
            end
            mau_pkg::REQ_SUB: begin
              res   <= sub_ab[W-1:0];
              state <= S_DONE;
            end
            mau_pkg::REQ_NEG: begin
              res   <= (ar != '0) ? (m - ar) : '0;
              state <= S_DONE;
            end
            mau_pkg::REQ_MUL: begin
              x     <= ar;
              y     <= br;
              mdest <= DST_RES;
              state <= S_MUL;
            end
            mau_pkg::REQ_DIV: begin
              ea    <= br;
              eb    <= m;
              eu    <= CW'(1);
              ev    <= '0;
              state <= S_EU_CHK;
            end
            mau_pkg::REQ_INV: begin
              ea    <= ar;
              eb    <= m;
              eu    <= CW'(1);
              ev    <= '0;
              state <= S_EU_CHK;
            end
            default: begin
              acc   <= W'(1);
              sq    <= ar;
              state <= S_POW_CHK;
            end
          endcase
        end
        S_MUL: begin
          prod  <= x * y;
          state <= S_MULL;
        end
        S_MULL: begin
          div_dividend       <= 64'(prod);
          div_ctl.start      <= 1'b1;
          div_ctl.short_mode <= 1'b0;
          state              <= S_MULR;
        end
        S_MULR: begin
          if (div_done) begin
            case (mdest)
              DST_ACC: begin
                acc   <= div_rem;
                state <= S_POW_SQ;
              end
              DST_SQ: begin
                sq    <= div_rem;
                e     <= {1'b0, e[63:1]};
                state <= S_POW_CHK;
              end
              default: begin
                res   <= div_rem;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_EU_CHK: begin
          if (eb == '0) begin
            state <= S_EU_FIN;
          end else begin
            div_dividend       <= {{(64-W){1'b0}}, ea};
            div_ctl.start      <= 1'b1;
            div_ctl.short_mode <= 1'b1;
            state              <= S_EU_DIV;
          end
        end
        S_EU_DIV: begin
          if (div_done) begin
            ea    <= eb;
            eb    <= div_rem;
            eu    <= ev;
            ev    <= nu;
            state <= S_EU_CHK;
          end
        end
        S_EU_FIN: begin
          if (kind == mau_pkg::REQ_DIV) begin
            x     <= ar;
            y     <= u_fix[W-1:0];
            mdest <= DST_RES;
            state <= S_MUL;
          end else begin
            res   <= u_fix[W-1:0];
            state <= S_DONE;
          end
        end
        S_POW_CHK: begin
          if (e == 64'd0) begin
            if (eneg) begin
              ea    <= acc;
              eb    <= m;
              eu    <= CW'(1);
              ev    <= '0;
              state <= S_EU_CHK;
            end else begin
              res   <= acc;
              state <= S_DONE;
            end
          end else if (e[0]) begin
            x     <= acc;
            y     <= sq;
            mdest <= DST_ACC;
            state <= S_MUL;
          end else begin
            state <= S_POW_SQ;
          end
        end
        S_POW_SQ: begin
          x     <= sq;
          y     <= sq;
          mdest <= DST_SQ;
          state <= S_MUL;
        end
        S_DONE: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
